@@ hdl/video_test_pattern_generator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the pattern generator modules.
// They expect clk_i and rst_ni in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef VIDEO_TEST_PATTERN_GENERATOR_UNIT_MACROS_SVH
`define VIDEO_TEST_PATTERN_GENERATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define VTPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define VTPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/vtpg_pkg.sv @@
// ----------------------------------------------------------------------------
// vtpg_pkg
// Types, constants and helpers shared by the test pattern generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vtpg_pkg;

  localparam int unsigned ColW     = 10;
  localparam int unsigned RowW     = 10;
  localparam int unsigned RgbW     = 12;
  localparam int unsigned PatW     = 3;
  localparam int unsigned HoldW    = 12;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 12;

  // Defaults for the top-level parameters
  localparam int unsigned LineWidthDef = 1024;
  localparam int unsigned TileShiftDef = 5;

  // Pattern codes
  typedef enum logic [PatW-1:0] {
    PAT_BARS    = 3'd0,
    PAT_CHECKER = 3'd1,
    PAT_RED     = 3'd2,
    PAT_GREEN   = 3'd3,
    PAT_BLUE    = 3'd4
  } pattern_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START_PATTERN = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_FRAMES   = 1'd1;

  localparam pattern_e           StartPatternRst = PAT_RED;
  localparam logic [HoldW-1:0]   HoldFramesRst   = 12'd120;

  // RGB444 colors
  localparam logic [RgbW-1:0] RGB_RED     = 12'hF00;
  localparam logic [RgbW-1:0] RGB_GREEN   = 12'h0F0;
  localparam logic [RgbW-1:0] RGB_BLUE    = 12'h00F;
  localparam logic [RgbW-1:0] RGB_YELLOW  = 12'hFF0;
  localparam logic [RgbW-1:0] RGB_CYAN    = 12'h0FF;
  localparam logic [RgbW-1:0] RGB_MAGENTA = 12'hF0F;
  localparam logic [RgbW-1:0] RGB_WHITE   = 12'hFFF;
  localparam logic [RgbW-1:0] RGB_BLACK   = 12'h000;

  // Frame-end event from the pixel pipeline to the pattern control
  typedef struct packed {
    logic accept;  // input transaction taken this cycle
    logic last;    // it carries the end-of-frame mark
  } frame_evt_t;

  // Out-of-range start codes fall back to color bars
  function automatic pattern_e legal_pattern(input logic [PatW-1:0] p);
    pattern_e r;
    r = PAT_BARS;
    if (p <= PatW'(PAT_BLUE)) begin
      r = pattern_e'(p);
    end
    return r;
  endfunction

  // Bar palette, left to right
  function automatic logic [RgbW-1:0] bar_color(input logic [2:0] idx);
    logic [RgbW-1:0] c;
    case (idx)
      3'd0:    c = RGB_RED;
      3'd1:    c = RGB_GREEN;
      3'd2:    c = RGB_BLUE;
      3'd3:    c = RGB_YELLOW;
      3'd4:    c = RGB_CYAN;
      3'd5:    c = RGB_MAGENTA;
      3'd6:    c = RGB_WHITE;
      default: c = RGB_BLACK;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/video_test_pattern_generator_unit.sv @@
// A one-pixel-per-cycle test pattern source: while not stalled it accepts one
// pixel position per clock and returns its RGB444 color two registers later
// (input register, then result register); stalls back-propagate through those
// two stages. Patterns are color bars, a checkerboard, and solid red, green
// and blue; the pattern advances after hold_frames completed frames. Config:
// index 0 start_pattern (loads the pattern and clears the frame count), index
// 1 hold_frames.
// ----------------------------------------------------------------------------
// video_test_pattern_generator_unit
// Top level: pixel pipeline plus pattern/hold control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module video_test_pattern_generator_unit
  import vtpg_pkg::*;
#(
  parameter int unsigned LINE_WIDTH = LineWidthDef,
  parameter int unsigned TILE_SHIFT = TileShiftDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ColW-1:0]     pixel_col_i,
  input  logic [RowW-1:0]     pixel_row_i,
  input  logic                frame_last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RgbW-1:0]     pixel_rgb_o,
  output logic [PatW-1:0]     pattern_shown_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  pattern_e   pattern;
  frame_evt_t evt;

  vtpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .evt_i       (evt),
    .pattern_o   (pattern)
  );

  vtpg_pixel_pipe #(
    .LINE_WIDTH (LINE_WIDTH),
    .TILE_SHIFT (TILE_SHIFT)
  ) u_pipe (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pixel_col_i     (pixel_col_i),
    .pixel_row_i     (pixel_row_i),
    .frame_last_i    (frame_last_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_rgb_o     (pixel_rgb_o),
    .pattern_shown_o (pattern_shown_o),
    .pattern_i       (pattern),
    .evt_o           (evt)
  );

endmodule

@@ hdl/vtpg_ctrl.sv @@
// ----------------------------------------------------------------------------
// vtpg_ctrl
// Configuration registers, current pattern and frame hold counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "video_test_pattern_generator_unit_macros.svh"

module vtpg_ctrl
  import vtpg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  frame_evt_t          evt_i,
  output pattern_e            pattern_o
);

  logic [HoldW-1:0] hold_q, hold_d;
  logic [HoldW-1:0] held_q, held_d;
  pattern_e         pat_q, pat_d;
  logic [HoldW-1:0] held_inc;
  logic             cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;
  assign held_inc    = held_q + HoldW'(1);

  // Next state: a config write has priority and suppresses frame-end bookkeeping
  always_comb begin
    hold_d = hold_q;
    held_d = held_q;
    pat_d  = pat_q;
    if (cfg_wr) begin
      case (cfg_index_i)
        CFG_START_PATTERN: begin
          pat_d  = legal_pattern(cfg_data_i[PatW-1:0]);
          held_d = '0;
        end
        CFG_HOLD_FRAMES: begin
          hold_d = cfg_data_i[HoldW-1:0];
        end
        default: ;
      endcase
    end else if (evt_i.accept && evt_i.last) begin
      // a zero hold acts as one: wrap to zero also advances
      if ((held_inc >= hold_q) || (held_inc == '0)) begin
        held_d = '0;
        pat_d  = (pat_q == PAT_BLUE) ? PAT_BARS : pattern_e'(pat_q + PatW'(1));
      end else begin
        held_d = held_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HoldFramesRst;
      held_q <= '0;
      pat_q  <= StartPatternRst;
    end else begin
      hold_q <= hold_d;
      held_q <= held_d;
      pat_q  <= pat_d;
    end
  end

  assign pattern_o = pat_q;

  // Checks
  `VTPG_ASSERT_NEXT(a_pat_only_on_event,
    !cfg_wr && !(evt_i.accept && evt_i.last), $stable(pat_q),
    "pattern changed without frame end or config write")
  `VTPG_ASSERT_NEXT(a_held_step, !cfg_wr && evt_i.accept && evt_i.last,
    (held_q == '0) || (held_q == $past(held_inc)),
    "hold counter did not step or clear at frame end")
  `VTPG_ASSERT_NEXT(a_start_clears, cfg_wr && (cfg_index_i == CFG_START_PATTERN),
    held_q == '0, "start pattern write did not clear hold counter")

endmodule

@@ hdl/vtpg_pixel_pipe.sv @@
// ----------------------------------------------------------------------------
// vtpg_pixel_pipe
// Two-register pixel pipeline: input register, color logic, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "video_test_pattern_generator_unit_macros.svh"

module vtpg_pixel_pipe
  import vtpg_pkg::*;
#(
  parameter int unsigned LINE_WIDTH = LineWidthDef,
  parameter int unsigned TILE_SHIFT = TileShiftDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ColW-1:0]  pixel_col_i,
  input  logic [RowW-1:0]  pixel_row_i,
  input  logic             frame_last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [RgbW-1:0]  pixel_rgb_o,
  output logic [PatW-1:0]  pattern_shown_o,
  input  pattern_e         pattern_i,
  output frame_evt_t       evt_o
);

  // col*8 of the widest line fits here
  localparam int unsigned CmpW = 13;

  logic            s1_valid_q;
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;
  pattern_e        s1_pat_q;

  logic            out_valid_q;
  logic [RgbW-1:0] out_rgb_q, out_rgb_d;
  pattern_e        out_pat_q;

  logic            s2_ready;
  logic            s1_ready;
  logic            in_accept;
  logic [6:0]      bar_hit;
  logic [2:0]      bar_idx;
  logic            tile_odd;

  // Handshake
  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign in_accept  = in_valid_i && s1_ready;

  assign evt_o.accept = in_accept;
  assign evt_o.last   = frame_last_i;

  // Input register: pixel position and the pattern in force at acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_col_q <= pixel_col_i;
      s1_row_q <= pixel_row_i;
      s1_pat_q <= pattern_i;
    end
  end

  // Bar boundaries: col*8/LINE_WIDTH >= k  <=>  col >= ceil(k*LINE_WIDTH/8)
  for (genvar k = 0; k < 7; k++) begin : g_bar
    localparam int unsigned Th = ((k + 1) * LINE_WIDTH + 7) / 8;
    assign bar_hit[k] = CmpW'(s1_col_q) >= CmpW'(Th);
  end

  always_comb begin
    bar_idx = '0;
    for (int k = 0; k < 7; k++) begin
      bar_idx = bar_idx + 3'(bar_hit[k]);
    end
  end

  // Checkerboard: parity of tile column plus tile row
  assign tile_odd = s1_col_q[TILE_SHIFT] ^ s1_row_q[TILE_SHIFT];

  // Color select
  always_comb begin
    case (s1_pat_q)
      PAT_CHECKER: out_rgb_d = tile_odd ? RGB_BLACK : RGB_WHITE;
      PAT_RED:     out_rgb_d = RGB_RED;
      PAT_GREEN:   out_rgb_d = RGB_GREEN;
      PAT_BLUE:    out_rgb_d = RGB_BLUE;
      default:     out_rgb_d = bar_color(bar_idx);
    endcase
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      out_rgb_q <= out_rgb_d;
      out_pat_q <= s1_pat_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_rgb_o     = out_rgb_q;
  assign pattern_shown_o = PatW'(out_pat_q);

  // Checks
  `VTPG_ASSERT_NEXT(a_pat_carried, s1_valid_q && s2_ready,
    out_valid_q && (out_pat_q == $past(s1_pat_q)),
    "result pattern does not match the staged pixel")

endmodule

@@ sim/video_test_pattern_generator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// video_test_pattern_generator_unit_tb
// Self-checking bench for the test pattern generator. A clocked driver feeds
// pixel positions from a pending queue, and an in-bench color predictor
// computes each pixel's expected color and pattern. A clocked monitor
// checks every output transaction against the oldest expected pixel. The
// run has directed pixels for every pattern and frame-count corner, then
// random short frames under several register settings with random gaps and
// stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module video_test_pattern_generator_unit_tb;
  import vtpg_pkg::*;

  localparam int LINE_W       = LineWidthDef;
  localparam int TILE_SH      = TileShiftDef;
  localparam int ITEMS_PER_PH = 83;
  localparam int NUM_PHASES   = 10;
  localparam int HOLD_AT_ITEM = 300;
  localparam int HOLD_CYCLES  = 200;
  localparam int PIPE_CYCLES  = 4;

  localparam logic [RgbW-1:0] BAR_RGB [8] = '{
    RGB_RED, RGB_GREEN, RGB_BLUE, RGB_YELLOW,
    RGB_CYAN, RGB_MAGENTA, RGB_WHITE, RGB_BLACK
  };

  typedef struct {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            last;
  } pixel_pos_t;

  typedef struct {
    logic [RgbW-1:0] rgb;
    pattern_e        pat;
  } pixel_color_t;

  // DUT signals
  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ColW-1:0]     pixel_col_i;
  logic [RowW-1:0]     pixel_row_i;
  logic                frame_last_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [RgbW-1:0]     pixel_rgb_o;
  logic [PatW-1:0]     pattern_shown_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Bench state
  pixel_pos_t   pixel_pending_q[$];
  pixel_color_t pixel_expect_q[$];
  int           err_count;
  int           in_count;
  int           add_count;
  logic         in_acc;
  int           tx_gap_left;
  int           rx_stall_left;
  int           rx_hold_left;
  logic         rx_hold_done;
  int           tx_idle_pct;
  int           rx_stall_pct;

  // Predicted generator state
  pattern_e         gen_pattern;
  logic [HoldW-1:0] gen_frames;
  logic [HoldW-1:0] gen_hold;

  video_test_pattern_generator_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_col_i    (pixel_col_i),
    .pixel_row_i    (pixel_row_i),
    .frame_last_i   (frame_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_rgb_o    (pixel_rgb_o),
    .pattern_shown_o(pattern_shown_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Clock
  always #6 clk_i = ~clk_i;

  // Color of one pixel under a given pattern
  function automatic logic [RgbW-1:0] paint_color(pattern_e pat, logic [ColW-1:0] col,
                                                  logic [RowW-1:0] row);
    int bar;
    int tile;
    logic [RgbW-1:0] c;
    case (pat)
      PAT_CHECKER: begin
        tile = ((int'(col) >> TILE_SH) + (int'(row) >> TILE_SH)) & 1;
        c = (tile != 0) ? RGB_BLACK : RGB_WHITE;
      end
      PAT_RED:   c = RGB_RED;
      PAT_GREEN: c = RGB_GREEN;
      PAT_BLUE:  c = RGB_BLUE;
      default: begin
        bar = (int'(col) * 8) / LINE_W;
        if (bar > 7) bar = 7;
        c = BAR_RGB[bar];
      end
    endcase
    return c;
  endfunction

  function automatic pattern_e step_pattern(pattern_e p);
    pattern_e n;
    case (p)
      PAT_BARS:    n = PAT_CHECKER;
      PAT_CHECKER: n = PAT_RED;
      PAT_RED:     n = PAT_GREEN;
      PAT_GREEN:   n = PAT_BLUE;
      default:     n = PAT_BARS;
    endcase
    return n;
  endfunction

  // Expected color for an accepted pixel, then the frame-count update
  task automatic predict_pixel(logic [ColW-1:0] col, logic [RowW-1:0] row, logic last);
    pixel_color_t e;
    e.rgb = paint_color(gen_pattern, col, row);
    e.pat = gen_pattern;
    pixel_expect_q.push_back(e);
    if (last) begin
      gen_frames = gen_frames + 1'b1;
      if (gen_frames >= gen_hold || gen_frames == '0) begin
        gen_frames  = '0;
        gen_pattern = step_pattern(gen_pattern);
      end
    end
  endtask

  // Short gaps mostly, a few long ones
  function automatic int pick_gap(int pct);
    int r;
    if ($urandom_range(99) >= pct) return 0;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Sample side: check outputs, then predict for the accepted input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pixel_expect_q.size() == 0) begin
          $error("unexpected pixel: rgb %03h pattern %0d", pixel_rgb_o, pattern_shown_o);
          err_count++;
        end else begin
          if (pixel_rgb_o !== pixel_expect_q[0].rgb) begin
            $error("pixel_rgb: expected %03h, actual %03h",
                   pixel_expect_q[0].rgb, pixel_rgb_o);
            err_count++;
          end
          if (pattern_shown_o !== PatW'(pixel_expect_q[0].pat)) begin
            $error("pattern_shown: expected %0d, actual %0d",
                   pixel_expect_q[0].pat, pattern_shown_o);
            err_count++;
          end
          void'(pixel_expect_q.pop_front());
        end
      end
      if (in_valid_i && !in_stall_o) begin
        predict_pixel(pixel_col_i, pixel_row_i, frame_last_i);
        in_count++;
      end
    end
    in_acc <= in_valid_i && !in_stall_o;
  end

  // Pixel driver: hold a stalled transaction, else idle or send the next one
  always @(negedge clk_i) begin
    pixel_pos_t p;
    if (in_valid_i && !in_acc) begin
      // keep offering the same pixel
    end else if (tx_gap_left > 0) begin
      in_valid_i  <= 1'b0;
      tx_gap_left <= tx_gap_left - 1;
    end else if (pixel_pending_q.size() != 0) begin
      p = pixel_pending_q.pop_front();
      in_valid_i   <= 1'b1;
      pixel_col_i  <= p.col;
      pixel_row_i  <= p.row;
      frame_last_i <= p.last;
      tx_gap_left  <= pick_gap(tx_idle_pct);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver stalls, with one long hold-off once the stream is going
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_stall_i  <= 1'b1;
      rx_hold_left <= rx_hold_left - 1;
    end else if (!rx_hold_done && in_count >= HOLD_AT_ITEM) begin
      out_stall_i  <= 1'b1;
      rx_hold_left <= HOLD_CYCLES - 1;
      rx_hold_done <= 1'b1;
    end else if (rx_stall_left > 0) begin
      out_stall_i   <= 1'b1;
      rx_stall_left <= rx_stall_left - 1;
    end else begin
      out_stall_i   <= 1'b0;
      rx_stall_left <= pick_gap(rx_stall_pct);
    end
  end

  task automatic add_pixel(int col, int row, logic last);
    pixel_pos_t p;
    p.col  = ColW'(col);
    p.row  = RowW'(row);
    p.last = last;
    pixel_pending_q.push_back(p);
    add_count++;
  endtask

  // Wait until every queued pixel is accepted and checked, then let things settle
  task automatic wait_drained(int extra);
    while (in_count != add_count || pixel_expect_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (extra) @(negedge clk_i);
  endtask

  // One register write transaction; the predictor follows at the write edge
  task automatic reg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_START_PATTERN) begin
      if (data[PatW-1:0] <= PatW'(PAT_BLUE)) gen_pattern = pattern_e'(data[PatW-1:0]);
      else gen_pattern = PAT_BARS;
      gen_frames = '0;
    end else begin
      gen_hold = data[HoldW-1:0];
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stimulus
  initial begin
    int len;
    int n;
    int row;
    logic [HoldW-1:0] hold;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    pixel_col_i   = '0;
    pixel_row_i   = '0;
    frame_last_i  = 1'b0;
    out_stall_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_START_PATTERN;
    cfg_data_i    = '0;
    err_count     = 0;
    in_count      = 0;
    add_count     = 0;
    in_acc        = 1'b0;
    tx_gap_left   = 0;
    rx_stall_left = 0;
    rx_hold_left  = 0;
    rx_hold_done  = 1'b0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    gen_pattern   = StartPatternRst;
    gen_frames    = '0;
    gen_hold      = HoldFramesRst;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset pattern at both corners
    add_pixel(0, 0, 1'b0);
    add_pixel(1023, 1023, 1'b0);
    wait_drained(PIPE_CYCLES);

    // Advance every frame; an out-of-range start code falls back to bars
    reg_write(CFG_HOLD_FRAMES, 12'd1);
    reg_write(CFG_START_PATTERN, 12'hFFF);
    tx_idle_pct  = 40;
    rx_stall_pct = 40;
    // One pixel per bar, both line ends included
    add_pixel(0, 5, 1'b0);
    add_pixel(127, 5, 1'b0);
    add_pixel(128, 5, 1'b0);
    add_pixel(256, 5, 1'b0);
    add_pixel(384, 5, 1'b0);
    add_pixel(512, 5, 1'b0);
    add_pixel(640, 5, 1'b0);
    add_pixel(768, 5, 1'b0);
    add_pixel(1023, 767, 1'b1);
    // Checkerboard tile edges
    add_pixel(0, 0, 1'b0);
    add_pixel(32, 0, 1'b0);
    add_pixel(32, 32, 1'b0);
    add_pixel(1023, 0, 1'b0);
    add_pixel(1023, 1023, 1'b1);
    // Solid red, green, blue, then wrap to bars
    add_pixel(5, 5, 1'b1);
    add_pixel(5, 5, 1'b1);
    add_pixel(5, 5, 1'b1);
    wait_drained(PIPE_CYCLES);

    // Hold of zero advances after every frame
    reg_write(CFG_HOLD_FRAMES, 12'd0);
    add_pixel(700, 3, 1'b1);
    wait_drained(PIPE_CYCLES);

    // Hold lowered below the frame count advances at the next frame end
    reg_write(CFG_HOLD_FRAMES, 12'd3);
    add_pixel(1, 1, 1'b1);
    add_pixel(2, 2, 1'b1);
    wait_drained(PIPE_CYCLES);
    reg_write(CFG_HOLD_FRAMES, 12'd1);
    add_pixel(3, 3, 1'b1);
    wait_drained(PIPE_CYCLES);

    // Random phases of short frames under changing settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       hold = 12'd1;
        1:       hold = 12'd2;
        2:       hold = 12'd4095;
        3:       hold = 12'd0;
        4:       hold = 12'd3;
        5:       hold = HoldW'($urandom_range(0, 4095));
        6:       hold = HoldW'($urandom_range(1, 5));
        default: hold = HoldW'($urandom_range(1, 4));
      endcase
      reg_write(CFG_START_PATTERN,
                {CfgDataW'($urandom_range(0, 511)) << PatW} |
                CfgDataW'((ph < 8) ? ph : $urandom_range(0, 7)));
      reg_write(CFG_HOLD_FRAMES, CfgDataW'(hold));
      tx_idle_pct  = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 30 : 70);
      rx_stall_pct = (ph % 4 == 1) ? 0 : ((ph % 2 == 0) ? 30 : 70);
      n = 0;
      while (n < ITEMS_PER_PH) begin
        if ($urandom_range(9) == 0) begin
          // noise: a stray pixel with a random frame mark
          add_pixel($urandom_range(0, 1023), $urandom_range(0, 1023),
                    1'($urandom_range(0, 1)));
          n++;
        end else begin
          len = $urandom_range(1, 8);
          for (int i = 0; i < len; i++) begin
            row = ($urandom_range(9) == 0) ? $urandom_range(768, 1023)
                                           : $urandom_range(0, 767);
            add_pixel($urandom_range(0, 1023), row, i == len - 1);
          end
          n += len;
        end
      end
      wait_drained(PIPE_CYCLES);
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
